// ----- hdl/rcss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Resonant converter soft-start package
// Shared constants, register indexes, phase codes and the structures that
// travel between the register file, the sequencer core and the top level.
// ----------------------------------------------------------------------------
package rcss_pkg;

    localparam int unsigned RCSS_COUNT_WIDTH = 16;
    localparam int unsigned RCSS_ADDR_W      = 5;
    localparam int unsigned RCSS_DATA_W      = 32;

    localparam int unsigned RCSS_PAUSE_INIT  = 500;
    localparam int unsigned RCSS_HOLD_INIT   = 800;
    localparam int unsigned RCSS_HOLD_RELOAD = 50000;

    localparam logic [15:0] RCSS_NOMINAL_PERIOD_RST = 16'd1000;
    localparam logic [15:0] RCSS_PERIOD_FLOOR_RST   = 16'd500;
    localparam logic [15:0] RCSS_PERIOD_CEILING_RST = 16'd2000;
    localparam logic [14:0] RCSS_START_DUTY_RST     = 15'd10;
    localparam logic [14:0] RCSS_DEAD_TIME_RST      = 15'd50;
    localparam logic [14:0] RCSS_DEAD_TIME_CAP_RST  = 15'd150;
    localparam logic [15:0] RCSS_PAUSE_RELOAD_RST   = 16'd800;
    localparam logic [15:0] RCSS_RAMP_DIVIDER_RST   = 16'd300;

    localparam logic signed [15:0] RCSS_BUS_TRIP_HIGH  = 16'sd4500;
    localparam logic signed [15:0] RCSS_BUS_RESUME_LOW = 16'sd4400;
    localparam logic signed [15:0] RCSS_BUS_WORK_MIN   = 16'sd3000;
    localparam logic [15:0]        RCSS_DUTY_WORK_MIN  = 16'd300;

    typedef enum logic [2:0] {
        REG_NOMINAL_PERIOD    = 3'd0,
        REG_PERIOD_FLOOR      = 3'd1,
        REG_PERIOD_CEILING    = 3'd2,
        REG_START_DUTY        = 3'd3,
        REG_DEAD_TIME_SETTING = 3'd4,
        REG_DEAD_TIME_CAP     = 3'd5,
        REG_PAUSE_RELOAD      = 3'd6,
        REG_RAMP_DIVIDER      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_OFF    = 3'd0,
        PH_PAUSE  = 3'd1,
        PH_HOLD   = 3'd2,
        PH_RAMP   = 3'd3,
        PH_STEADY = 3'd4
    } t_phase;

    typedef struct packed {
        logic [15:0] nominal_period;
        logic [15:0] period_floor;
        logic [15:0] period_ceiling;
        logic [14:0] start_duty;
        logic [14:0] dead_time_setting;
        logic [14:0] dead_time_cap;
        logic [15:0] pause_reload;
        logic [15:0] ramp_divider;
    } t_cfg;

    typedef struct packed {
        logic        en;
        logic [14:0] value;
    } t_dt_wb;

    typedef struct packed {
        t_phase      phase;
        logic        drive_on;
        logic [15:0] period_out;
        logic [14:0] duty_out;
        logic [15:0] complement_compare;
        logic        work_ready;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/rcss_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Resonant converter soft-start channel interfaces
// Valid/ready channels for the control tick input and the compare result.
// ----------------------------------------------------------------------------
interface rcss_in_if;
    logic               valid;
    logic               ready;
    logic               run_enable;
    logic signed [15:0] bus_voltage;

    modport source (output valid, output run_enable, output bus_voltage, input ready);
    modport sink (input valid, input run_enable, input bus_voltage, output ready);
endinterface

interface rcss_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic        drive_on;
    logic [15:0] period_out;
    logic [14:0] duty_out;
    logic [15:0] complement_compare;
    logic        work_ready;

    modport source (
        output valid, output phase, output drive_on, output period_out,
        output duty_out, output complement_compare, output work_ready, input ready
    );
    modport sink (
        input valid, input phase, input drive_on, input period_out,
        input duty_out, input complement_compare, input work_ready, output ready
    );
endinterface
`default_nettype wire

// ----- hdl/rcss_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-start register file
// APB-style configuration registers, including the dead time write-back
// that stores the clamped dead time after every enabled tick.
// ----------------------------------------------------------------------------
module rcss_regs import rcss_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [RCSS_ADDR_W-1:0] paddr,
    input  wire logic [RCSS_DATA_W-1:0] pwdata,
    output logic      [RCSS_DATA_W-1:0] prdata,
    input  wire t_dt_wb                 i_dt_wb,
    output t_cfg                        o_cfg
);

    logic [15:0] r_nominal_period;
    logic [15:0] r_period_floor;
    logic [15:0] r_period_ceiling;
    logic [14:0] r_start_duty;
    logic [14:0] r_dead_time_setting;
    logic [14:0] r_dead_time_cap;
    logic [15:0] r_pause_reload;
    logic [15:0] r_ramp_divider;

    logic     wr_en;
    t_reg_idx reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[RCSS_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal_period    <= RCSS_NOMINAL_PERIOD_RST;
            r_period_floor      <= RCSS_PERIOD_FLOOR_RST;
            r_period_ceiling    <= RCSS_PERIOD_CEILING_RST;
            r_start_duty        <= RCSS_START_DUTY_RST;
            r_dead_time_setting <= RCSS_DEAD_TIME_RST;
            r_dead_time_cap     <= RCSS_DEAD_TIME_CAP_RST;
            r_pause_reload      <= RCSS_PAUSE_RELOAD_RST;
            r_ramp_divider      <= RCSS_RAMP_DIVIDER_RST;
        end else begin
            if (i_dt_wb.en) begin
                r_dead_time_setting <= i_dt_wb.value;
            end
            if (wr_en) begin
                case (reg_idx)
                    REG_NOMINAL_PERIOD:    r_nominal_period    <= pwdata[15:0];
                    REG_PERIOD_FLOOR:      r_period_floor      <= pwdata[15:0];
                    REG_PERIOD_CEILING:    r_period_ceiling    <= pwdata[15:0];
                    REG_START_DUTY:        r_start_duty        <= pwdata[14:0];
                    REG_DEAD_TIME_SETTING: r_dead_time_setting <= pwdata[14:0];
                    REG_DEAD_TIME_CAP:     r_dead_time_cap     <= pwdata[14:0];
                    REG_PAUSE_RELOAD:      r_pause_reload      <= pwdata[15:0];
                    REG_RAMP_DIVIDER:      r_ramp_divider      <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NOMINAL_PERIOD:    prdata = {16'd0, r_nominal_period};
            REG_PERIOD_FLOOR:      prdata = {16'd0, r_period_floor};
            REG_PERIOD_CEILING:    prdata = {16'd0, r_period_ceiling};
            REG_START_DUTY:        prdata = {17'd0, r_start_duty};
            REG_DEAD_TIME_SETTING: prdata = {17'd0, r_dead_time_setting};
            REG_DEAD_TIME_CAP:     prdata = {17'd0, r_dead_time_cap};
            REG_PAUSE_RELOAD:      prdata = {16'd0, r_pause_reload};
            REG_RAMP_DIVIDER:      prdata = {16'd0, r_ramp_divider};
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.nominal_period    = r_nominal_period;
        o_cfg.period_floor      = r_period_floor;
        o_cfg.period_ceiling    = r_period_ceiling;
        o_cfg.start_duty        = r_start_duty;
        o_cfg.dead_time_setting = r_dead_time_setting;
        o_cfg.dead_time_cap     = r_dead_time_cap;
        o_cfg.pause_reload      = r_pause_reload;
        o_cfg.ramp_divider      = r_ramp_divider;
    end

endmodule
`default_nettype wire

// ----- hdl/rcss_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Soft-start sequencer core
// Holds the phase counters, duty, period and drive state, and computes the
// result of one control tick from the registered input transaction.
// ----------------------------------------------------------------------------
module rcss_core import rcss_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = RCSS_COUNT_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_run_enable,
    input  wire logic signed [15:0] i_bus_voltage,
    input  wire t_cfg               i_cfg,
    output t_dt_wb                  o_dt_wb,
    output t_result                 o_result
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] PAUSE_INIT  = COUNT_WIDTH'(RCSS_PAUSE_INIT);
    localparam logic [COUNT_WIDTH-1:0] HOLD_INIT   = COUNT_WIDTH'(RCSS_HOLD_INIT);
    localparam logic [COUNT_WIDTH-1:0] HOLD_RELOAD = COUNT_WIDTH'(RCSS_HOLD_RELOAD);

    logic [COUNT_WIDTH-1:0] r_pause_count, n_pause_count;
    logic [COUNT_WIDTH-1:0] r_hold_count, n_hold_count;
    logic [COUNT_WIDTH-1:0] r_ramp_tick_count, n_ramp_tick_count;
    logic [15:0]            r_duty_value, n_duty_value;
    logic [15:0]            r_period_value, n_period_value;
    logic                   r_drive_state, n_drive_state;

    logic [14:0]            dead_time;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_W-1:0]       tick_ext;
    logic [CMP_W-1:0]       div_ext;
    logic [CMP_W-1:0]       reload_ext;
    logic                   tick_hit;
    logic signed [16:0]     ramp_lim;
    logic signed [16:0]     steady_raw;
    logic signed [16:0]     limit_raw;
    logic [15:0]            limit_val;
    logic [15:0]            pre_period;
    logic [15:0]            pre_duty;
    logic                   gate_state;
    t_phase                 phase;

    always_comb begin
        if (i_cfg.dead_time_setting <= i_cfg.start_duty) begin
            dead_time = i_cfg.start_duty;
        end else if (i_cfg.dead_time_setting > i_cfg.dead_time_cap) begin
            dead_time = i_cfg.dead_time_cap;
        end else begin
            dead_time = i_cfg.dead_time_setting;
        end
    end

    assign tick_inc   = r_ramp_tick_count + 1'b1;
    assign tick_ext   = CMP_W'(tick_inc);
    assign div_ext    = CMP_W'(i_cfg.ramp_divider);
    assign reload_ext = CMP_W'(i_cfg.pause_reload);
    assign tick_hit   = tick_ext >= div_ext;

    assign ramp_lim   = $signed({2'b00, i_cfg.nominal_period[15:1]})
                      - $signed({2'b00, dead_time});
    assign steady_raw = $signed({2'b00, r_period_value[15:1]})
                      - $signed({2'b00, dead_time});

    always_comb begin
        if (i_bus_voltage >= RCSS_BUS_TRIP_HIGH) begin
            gate_state = 1'b0;
        end else if (i_bus_voltage <= RCSS_BUS_RESUME_LOW) begin
            gate_state = 1'b1;
        end else begin
            gate_state = r_drive_state;
        end
    end

    always_comb begin
        n_pause_count     = r_pause_count;
        n_hold_count      = r_hold_count;
        n_ramp_tick_count = r_ramp_tick_count;
        n_drive_state     = r_drive_state;
        pre_period        = r_period_value;
        pre_duty          = r_duty_value;
        if (!i_run_enable) begin
            phase = PH_OFF;
        end else if (r_pause_count != '0) begin
            phase = PH_PAUSE;
        end else if (r_hold_count != '0) begin
            phase = PH_HOLD;
        end else if ($signed({1'b0, r_duty_value}) < ramp_lim) begin
            phase = PH_RAMP;
        end else begin
            phase = PH_STEADY;
        end

        case (phase)
            PH_OFF: begin
                n_drive_state = 1'b0;
                pre_duty      = '0;
                pre_period    = i_cfg.period_floor;
                n_pause_count = reload_ext[COUNT_WIDTH-1:0];
                n_hold_count  = HOLD_RELOAD;
            end
            PH_PAUSE: begin
                n_pause_count = r_pause_count - 1'b1;
                n_drive_state = 1'b0;
                pre_duty      = '0;
                pre_period    = i_cfg.nominal_period;
            end
            PH_HOLD: begin
                n_hold_count  = r_hold_count - 1'b1;
                pre_duty      = {1'b0, i_cfg.start_duty};
                pre_period    = i_cfg.nominal_period;
                n_drive_state = 1'b1;
            end
            PH_RAMP: begin
                n_ramp_tick_count = tick_hit ? '0 : tick_inc;
                pre_duty          = r_duty_value + {15'd0, tick_hit};
                n_drive_state     = gate_state;
            end
            PH_STEADY: begin
                pre_duty      = steady_raw[16] ? 16'd0 : steady_raw[15:0];
                n_drive_state = gate_state;
            end
            default: begin
            end
        endcase

        if (phase == PH_OFF) begin
            n_period_value = pre_period;
        end else if (pre_period > i_cfg.period_ceiling) begin
            n_period_value = i_cfg.period_ceiling;
        end else if (pre_period < i_cfg.period_floor) begin
            n_period_value = i_cfg.period_floor;
        end else begin
            n_period_value = pre_period;
        end

        limit_raw = $signed({2'b00, n_period_value[15:1]}) - $signed({2'b00, dead_time});
        limit_val = limit_raw[16] ? 16'd0 : limit_raw[15:0];
        if (phase != PH_OFF && pre_duty > limit_val) begin
            n_duty_value = limit_val;
        end else begin
            n_duty_value = pre_duty;
        end
    end

    always_comb begin
        o_dt_wb.en    = i_step && i_run_enable;
        o_dt_wb.value = dead_time;

        o_result.phase              = phase;
        o_result.drive_on           = n_drive_state;
        o_result.period_out         = n_period_value;
        o_result.duty_out           = n_duty_value[14:0];
        o_result.complement_compare = n_period_value - n_duty_value;
        o_result.work_ready         = (phase != PH_OFF)
                                   && (i_bus_voltage >= RCSS_BUS_WORK_MIN)
                                   && (n_duty_value > RCSS_DUTY_WORK_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_count     <= PAUSE_INIT;
            r_hold_count      <= HOLD_INIT;
            r_ramp_tick_count <= '0;
            r_duty_value      <= '0;
            r_period_value    <= '0;
            r_drive_state     <= 1'b0;
        end else if (i_step) begin
            r_pause_count     <= n_pause_count;
            r_hold_count      <= n_hold_count;
            r_ramp_tick_count <= n_ramp_tick_count;
            r_duty_value      <= n_duty_value;
            r_period_value    <= n_period_value;
            r_drive_state     <= n_drive_state;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/resonant_converter_soft_start_unit.sv -----
// ----------------------------------------------------------------------------
// Resonant converter soft-start unit
// An accepted input transaction is registered in the input stage, and its result in the output stage.
// Throughput is one transaction per cycle while the output channel is not stalled.
// Synchronous active-low reset restores register defaults and sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none
module resonant_converter_soft_start_unit import rcss_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = RCSS_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    rcss_in_if.sink                     i_in,
    rcss_out_if.source                  o_out,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [RCSS_ADDR_W-1:0] paddr,
    input  wire logic [RCSS_DATA_W-1:0] pwdata,
    output logic      [RCSS_DATA_W-1:0] prdata,
    output logic                        pready
);

    logic               r_in_valid, n_in_valid;
    logic               r_in_run_enable;
    logic signed [15:0] r_in_bus_voltage;
    logic               r_out_valid, n_out_valid;
    t_result            r_res;

    logic    out_load;
    logic    step;
    logic    accept;
    t_cfg    cfg;
    t_dt_wb  dt_wb;
    t_result core_res;

    assign pready   = 1'b1;
    assign out_load = !r_out_valid || o_out.ready;
    assign step     = r_in_valid && out_load;
    assign i_in.ready = !r_in_valid || step;
    assign accept   = i_in.valid && i_in.ready;

    rcss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .i_dt_wb (dt_wb),
        .o_cfg   (cfg)
    );

    rcss_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_run_enable  (r_in_run_enable),
        .i_bus_voltage (r_in_bus_voltage),
        .i_cfg         (cfg),
        .o_dt_wb       (dt_wb),
        .o_result      (core_res)
    );

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_run_enable  <= i_in.run_enable;
            r_in_bus_voltage <= i_in.bus_voltage;
        end
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.phase              = r_res.phase;
    assign o_out.drive_on           = r_res.drive_on;
    assign o_out.period_out         = r_res.period_out;
    assign o_out.duty_out           = r_res.duty_out;
    assign o_out.complement_compare = r_res.complement_compare;
    assign o_out.work_ready         = r_res.work_ready;

    a_in_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("Pending input transaction was not moved to the output stage.");

    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.phase == PH_OFF |->
            r_res.duty_out == '0 && !r_res.drive_on && !r_res.work_ready)
        else $error("Off phase result has nonzero duty, drive or work ready.");

    a_ready_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.work_ready |-> r_res.duty_out > RCSS_DUTY_WORK_MIN[14:0])
        else $error("Work ready asserted with duty at or below the minimum.");

    a_pause_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.phase == PH_PAUSE |-> !r_res.drive_on && r_res.duty_out == '0)
        else $error("Pause phase result drives the bridge.");

endmodule
`default_nettype wire

// ----- tb/tb_resonant_converter_soft_start_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soft-start unit testbench
// Drives control ticks into the resonant converter soft-start unit through the
// input channel and programs its registers over the APB port while it is idle.
// A scoreboard keeps its own copy of the sequencer state and registers, predicts
// every result and compares each received result field by field. Both channels
// idle in random bursts, and register settings walk through the pause, hold,
// ramp and steady phases, clamping corners and random values.
// ----------------------------------------------------------------------------
module tb_resonant_converter_soft_start_unit;
    import rcss_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 50;

    class soft_start_scoreboard;
        t_cfg                        cfg;
        logic [RCSS_COUNT_WIDTH-1:0] pause_cnt;
        logic [RCSS_COUNT_WIDTH-1:0] hold_cnt;
        logic [RCSS_COUNT_WIDTH-1:0] ramp_ticks;
        int                          duty;
        int                          period;
        bit                          drive;
        t_result                     expected_q[$];
        int                          errors;
        int                          ticks;
        int                          results;
        bit [4:0]                    phases_seen;

        function new();
            cfg.nominal_period    = RCSS_NOMINAL_PERIOD_RST;
            cfg.period_floor      = RCSS_PERIOD_FLOOR_RST;
            cfg.period_ceiling    = RCSS_PERIOD_CEILING_RST;
            cfg.start_duty        = RCSS_START_DUTY_RST;
            cfg.dead_time_setting = RCSS_DEAD_TIME_RST;
            cfg.dead_time_cap     = RCSS_DEAD_TIME_CAP_RST;
            cfg.pause_reload      = RCSS_PAUSE_RELOAD_RST;
            cfg.ramp_divider      = RCSS_RAMP_DIVIDER_RST;
            pause_cnt   = RCSS_COUNT_WIDTH'(RCSS_PAUSE_INIT);
            hold_cnt    = RCSS_COUNT_WIDTH'(RCSS_HOLD_INIT);
            ramp_ticks  = '0;
            duty        = 0;
            period      = 0;
            drive       = 1'b0;
            errors      = 0;
            ticks       = 0;
            results     = 0;
            phases_seen = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_NOMINAL_PERIOD:    cfg.nominal_period    = v[15:0];
                REG_PERIOD_FLOOR:      cfg.period_floor      = v[15:0];
                REG_PERIOD_CEILING:    cfg.period_ceiling    = v[15:0];
                REG_START_DUTY:        cfg.start_duty        = v[14:0];
                REG_DEAD_TIME_SETTING: cfg.dead_time_setting = v[14:0];
                REG_DEAD_TIME_CAP:     cfg.dead_time_cap     = v[14:0];
                REG_PAUSE_RELOAD:      cfg.pause_reload      = v[15:0];
                REG_RAMP_DIVIDER:      cfg.ramp_divider      = v[15:0];
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void gate_drive(int volts);
            if (volts >= int'(RCSS_BUS_TRIP_HIGH)) begin
                drive = 1'b0;
            end else if (volts <= int'(RCSS_BUS_RESUME_LOW)) begin
                drive = 1'b1;
            end
        endfunction

        function void note_tick(bit en, logic signed [15:0] bus);
            int      volts;
            int      lim;
            int      ramp_top;
            int      dead;
            t_result r;
            volts = int'(bus);
            r.work_ready = 1'b0;
            if (!en) begin
                drive     = 1'b0;
                duty      = 0;
                period    = int'(cfg.period_floor);
                pause_cnt = cfg.pause_reload;
                hold_cnt  = RCSS_COUNT_WIDTH'(RCSS_HOLD_RELOAD);
                r.phase   = PH_OFF;
            end else begin
                // The clamped dead time is written back into the register copy.
                if (cfg.dead_time_setting <= cfg.start_duty) begin
                    cfg.dead_time_setting = cfg.start_duty;
                end else if (cfg.dead_time_setting > cfg.dead_time_cap) begin
                    cfg.dead_time_setting = cfg.dead_time_cap;
                end
                dead     = int'(cfg.dead_time_setting);
                ramp_top = int'(cfg.nominal_period >> 1) - dead;
                if (pause_cnt != 0) begin
                    pause_cnt = pause_cnt - 1'b1;
                    drive     = 1'b0;
                    duty      = 0;
                    period    = int'(cfg.nominal_period);
                    r.phase   = PH_PAUSE;
                end else if (hold_cnt != 0) begin
                    hold_cnt = hold_cnt - 1'b1;
                    duty     = int'(cfg.start_duty);
                    period   = int'(cfg.nominal_period);
                    drive    = 1'b1;
                    r.phase  = PH_HOLD;
                end else if (duty < ramp_top) begin
                    ramp_ticks = ramp_ticks + 1'b1;
                    if (ramp_ticks >= cfg.ramp_divider) begin
                        ramp_ticks = '0;
                        duty++;
                    end
                    gate_drive(volts);
                    r.phase = PH_RAMP;
                end else begin
                    lim  = (period >> 1) - dead;
                    duty = (lim < 0) ? 0 : lim;
                    gate_drive(volts);
                    r.phase = PH_STEADY;
                end
                if (period > int'(cfg.period_ceiling)) begin
                    period = int'(cfg.period_ceiling);
                end else if (period < int'(cfg.period_floor)) begin
                    period = int'(cfg.period_floor);
                end
                lim = (period >> 1) - dead;
                if (lim < 0) begin
                    lim = 0;
                end
                if (duty > lim) begin
                    duty = lim;
                end
                r.work_ready = (volts >= int'(RCSS_BUS_WORK_MIN)) &&
                               (duty > int'(RCSS_DUTY_WORK_MIN));
            end
            r.drive_on           = drive;
            r.period_out         = 16'(period);
            r.duty_out           = 15'(duty);
            r.complement_compare = 16'(period - duty);
            phases_seen[r.phase] = 1'b1;
            ticks++;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result transaction with no tick pending");
            end else begin
                want = expected_q.pop_front();
                if (got.phase !== want.phase) begin
                    report_mismatch($sformatf("result %0d phase: got %0d, expected %0d",
                        results, got.phase, want.phase));
                end
                if (got.drive_on !== want.drive_on) begin
                    report_mismatch($sformatf("result %0d drive_on: got %0d, expected %0d",
                        results, got.drive_on, want.drive_on));
                end
                if (got.period_out !== want.period_out) begin
                    report_mismatch($sformatf("result %0d period_out: got %0d, expected %0d",
                        results, got.period_out, want.period_out));
                end
                if (got.duty_out !== want.duty_out) begin
                    report_mismatch($sformatf("result %0d duty_out: got %0d, expected %0d",
                        results, got.duty_out, want.duty_out));
                end
                if (got.complement_compare !== want.complement_compare) begin
                    report_mismatch($sformatf("result %0d complement: got %0d, expected %0d",
                        results, got.complement_compare, want.complement_compare));
                end
                if (got.work_ready !== want.work_ready) begin
                    report_mismatch($sformatf("result %0d work_ready: got %0d, expected %0d",
                        results, got.work_ready, want.work_ready));
                end
                results++;
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [RCSS_ADDR_W-1:0] paddr;
    logic [RCSS_DATA_W-1:0] pwdata;
    logic [RCSS_DATA_W-1:0] prdata;
    logic                   pready;

    int idle_level;
    int settings_done = 0;

    soft_start_scoreboard sb = new();

    logic signed [15:0] corner_bus [0:13] = '{
        -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sh5555, -16'sd21846, 16'sd2999,
        16'sd3000, 16'sd4399, 16'sd4400, 16'sd4401, 16'sd4499, 16'sd4500, 16'sd4501
    };

    rcss_in_if  in_ch ();
    rcss_out_if out_ch ();

    resonant_converter_soft_start_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    function automatic logic signed [15:0] pick_bus();
        logic signed [15:0] b;
        case ($urandom_range(0, 5))
            0, 1:    b = 16'($urandom);
            2:       b = 16'(4401 + $urandom_range(0, 98));
            3:       b = 16'(4380 + $urandom_range(0, 140));
            4:       b = 16'(2990 + $urandom_range(0, 20));
            default: b = 16'($urandom_range(0, 4400));
        endcase
        return b;
    endfunction

    function automatic logic [31:0] pick_reg_value(t_reg_idx idx);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 60);
            default: v = $urandom_range(300, 3000);
        endcase
        if (idx == REG_RAMP_DIVIDER) begin
            v = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
        end else if (idx == REG_PAUSE_RELOAD && $urandom_range(0, 3) != 0) begin
            v = $urandom_range(0, 30);
        end
        if ($urandom_range(0, 7) == 0) begin
            v[31:16] = 16'($urandom);
        end
        return v;
    endfunction

    task automatic choose_idling();
        case ($urandom_range(0, 3))
            0:       idle_level = 0;
            1:       idle_level = 5;
            2:       idle_level = 20;
            default: idle_level = 50;
        endcase
    endtask

    task automatic send_tick(input bit en, input logic signed [15:0] bus);
        int gap;
        gap = 0;
        if (idle_level != 0 && $urandom_range(0, 99) < idle_level) begin
            gap = $urandom_range(1, 18);
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.run_enable  <= en;
        in_ch.bus_voltage <= bus;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        sb.note_tick(en, bus);
    endtask

    task automatic run_ticks(input int n, input int off_pct);
        int i;
        for (i = 0; i < n; i++) begin
            send_tick($urandom_range(0, 99) >= off_pct, pick_bus());
        end
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(input logic [31:0] nom, input logic [31:0] flo,
                             input logic [31:0] cei, input logic [31:0] sd,
                             input logic [31:0] dts, input logic [31:0] cap,
                             input logic [31:0] pr, input logic [31:0] div);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        apb_write(REG_NOMINAL_PERIOD, nom);
        apb_write(REG_PERIOD_FLOOR, flo);
        apb_write(REG_PERIOD_CEILING, cei);
        apb_write(REG_START_DUTY, sd);
        apb_write(REG_DEAD_TIME_SETTING, dts);
        apb_write(REG_DEAD_TIME_CAP, cap);
        apb_write(REG_PAUSE_RELOAD, pr);
        apb_write(REG_RAMP_DIVIDER, div);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_done++;
    endtask

    initial begin : result_sink
        int      stall_left;
        t_result got;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.phase              = t_phase'(out_ch.phase);
                got.drive_on           = out_ch.drive_on;
                got.period_out         = out_ch.period_out;
                got.duty_out           = out_ch.duty_out;
                got.complement_compare = out_ch.complement_compare;
                got.work_ready         = out_ch.work_ready;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_level != 0 && $urandom_range(0, 99) < idle_level) begin
                stall_left = $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int i;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.run_enable  <= 1'b0;
        in_ch.bus_voltage <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        idle_level = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stay enabled from reset so the short hold count leads into the ramp.
        write_all(800, 500, 2000, 10, 50, 150, 800, 1);
        for (i = 0; i < 14; i++) begin
            send_tick(1'b1, corner_bus[i]);
        end
        for (i = 0; i < 7; i++) begin
            choose_idling();
            run_ticks(200, 0);
        end

        write_all(1200, 1200, 2000, 10, 50, 150, 800, 0);
        run_ticks(80, 0);
        write_all(2000, 500, 2000, 10, 50, 150, 800, 3);
        run_ticks(40, 0);
        write_all(2000, 1500, 900, 10, 50, 150, 800, 3);
        run_ticks(30, 0);
        write_all(60, 500, 2000, 10, 32767, 32767, 800, 3);
        run_ticks(20, 0);
        write_all(1000, 500, 2000, 400, 600, 100, 800, 3);
        run_ticks(20, 0);
        write_all(65535, 0, 65535, 0, 0, 32767, 65535, 65535);
        run_ticks(20, 0);
        write_all(0, 65535, 65535, 32767, 32767, 0, 0, 2);
        run_ticks(20, 0);

        write_all(1000, 500, 2000, 10, 50, 150, 0, 1);
        send_tick(1'b0, 16'sd0);
        send_tick(1'b0, 16'sd32767);
        run_ticks(10, 0);

        for (i = 0; i < 4; i++) begin
            write_all(pick_reg_value(REG_NOMINAL_PERIOD), pick_reg_value(REG_PERIOD_FLOOR),
                      pick_reg_value(REG_PERIOD_CEILING), pick_reg_value(REG_START_DUTY),
                      pick_reg_value(REG_DEAD_TIME_SETTING), pick_reg_value(REG_DEAD_TIME_CAP),
                      pick_reg_value(REG_PAUSE_RELOAD), pick_reg_value(REG_RAMP_DIVIDER));
            choose_idling();
            run_ticks(15, 15);
        end

        idle_level = 0;
        run_ticks(40, 10);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d control ticks over %0d register settings.",
                 sb.results, sb.ticks, settings_done);
        $display("Phases reached (steady..off): %05b, mismatches counted: %0d",
                 sb.phases_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rcss_pkg.sv
hdl/rcss_if.sv
hdl/rcss_regs.sv
hdl/rcss_core.sv
hdl/resonant_converter_soft_start_unit.sv
tb/tb_resonant_converter_soft_start_unit.sv
